[rtl/core/u2u8_pkg.sv]
// Package for the UTF-16 to UTF-8 encoder: payload types, code point ranges,
// lead byte constants and the byte-building functions.
// Depends on nothing; every other file of the block imports it.
package u2u8_pkg;

    // Code unit ranges.
    localparam logic [15:0] ONE_BYTE_MAX = 16'h007F;
    localparam logic [15:0] TWO_BYTE_MAX = 16'h07FF;
    localparam logic [15:0] HIGH_FIRST   = 16'hD800;
    localparam logic [15:0] HIGH_LAST    = 16'hDBFF;
    localparam logic [15:0] LOW_FIRST    = 16'hDC00;
    localparam logic [15:0] LOW_LAST     = 16'hDFFF;

    // Lead and continuation byte patterns.
    localparam logic [7:0] LEAD_TWO       = 8'hC0;
    localparam logic [7:0] LEAD_THREE     = 8'hE0;
    localparam logic [7:0] LEAD_FOUR      = 8'hF0;
    localparam logic [7:0] LEAD_LONE_HIGH = 8'hF8;
    localparam logic [7:0] LEAD_LONE_LOW  = 8'hFC;
    localparam logic [7:0] CONT           = 8'h80;

    // Most bytes one code unit can cause, and the width of a byte count.
    localparam int MAX_BYTES = 8;
    localparam int COUNT_W   = 4;
    localparam int SURR_W    = 10;

    // Element 0 is always the first byte sent.
    typedef logic [3:0][7:0] quad_t;
    typedef logic [MAX_BYTES-1:0][7:0] octet_t;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        final_unit;
    } unit_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_end;
        logic       text_end;
    } byte_t;

    // Encoder result handed to the output serializer and the state registers.
    typedef struct packed {
        octet_t              bytes;
        logic [COUNT_W-1:0]  count;
        logic                final_unit;
        logic                held_valid;
        logic [SURR_W-1:0]   held_bits;
    } enc_result_t;

    // Plane number (top four surrogate bits plus one) of the four-byte form.
    function automatic logic [4:0] plane_of(input logic [SURR_W-1:0] bits);
        return {1'b0, bits[9:6]} + 5'd1;
    endfunction

    // Extended four-byte form of an unpaired high surrogate.
    function automatic quad_t lone_high(input logic [SURR_W-1:0] bits);
        quad_t      q;
        logic [4:0] plane;
        plane = plane_of(bits);
        q[0] = LEAD_LONE_HIGH;
        q[1] = CONT | {2'b00, plane[1:0], bits[5:2]};
        q[2] = CONT | {2'b00, bits[1:0], 4'h0};
        q[3] = CONT | {5'b00000, plane[4:2]};
        return q;
    endfunction

    // Standard four-byte form of a surrogate pair.
    function automatic quad_t pair_bytes(input logic [SURR_W-1:0] hi,
                                         input logic [SURR_W-1:0] lo);
        quad_t      q;
        logic [4:0] plane;
        plane = plane_of(hi);
        q[0] = LEAD_FOUR | {5'b00000, plane[4:2]};
        q[1] = CONT | {2'b00, plane[1:0], hi[5:2]};
        q[2] = CONT | {2'b00, hi[1:0], lo[9:6]};
        q[3] = CONT | {2'b00, lo[5:0]};
        return q;
    endfunction

endpackage

[rtl/core/u2u8_unit_if.sv]
// Channel interface that carries one UTF-16 code unit per transaction.
// Depends on u2u8_pkg for the payload type.
interface u2u8_unit_if
    import u2u8_pkg::*;
;
    logic  valid;
    logic  ready;
    unit_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/u2u8_byte_if.sv]
// Channel interface that carries one encoded byte per transaction.
// Depends on u2u8_pkg for the payload type.
interface u2u8_byte_if
    import u2u8_pkg::*;
;
    logic  valid;
    logic  ready;
    byte_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/u2u8_encode.sv]
// Combinational encoder: turns one registered code unit and the held surrogate
// into up to eight bytes, a byte count and the next held state.
// Depends on u2u8_pkg.
module u2u8_encode
    import u2u8_pkg::*;
(
    input  unit_t             item,
    input  logic              held_valid,
    input  logic [SURR_W-1:0] held_bits,
    output enc_result_t       result
);

    logic [15:0] u;
    logic        is_high;
    logic        is_low;
    logic        has_pre;
    quad_t       pre;
    quad_t       uq;
    logic [2:0]  ucnt;

    assign u       = item.code_unit;
    assign is_high = (u inside {[HIGH_FIRST:HIGH_LAST]});
    assign is_low  = (u inside {[LOW_FIRST:LOW_LAST]});

    // Bytes of the held surrogate (pair or lone form) and of the unit itself.
    always_comb
    begin
        has_pre = 1'b0;
        pre     = '0;
        uq      = '0;
        ucnt    = 3'd0;
        if (held_valid && is_low)
        begin
            has_pre = 1'b1;
            pre     = pair_bytes(held_bits, u[SURR_W-1:0]);
        end
        else
        begin
            if (held_valid)
            begin
                has_pre = 1'b1;
                pre     = lone_high(held_bits);
            end
            if (u <= ONE_BYTE_MAX)
            begin
                uq[0] = u[7:0];
                ucnt  = 3'd1;
            end
            else if (u <= TWO_BYTE_MAX)
            begin
                uq[0] = LEAD_TWO | {3'b000, u[10:6]};
                uq[1] = CONT | {2'b00, u[5:0]};
                ucnt  = 3'd2;
            end
            else if (is_high)
            begin
                // A high surrogate that ends the text has no partner to wait for.
                if (item.final_unit)
                begin
                    uq   = lone_high(u[SURR_W-1:0]);
                    ucnt = 3'd4;
                end
            end
            else if (is_low)
            begin
                uq[0] = LEAD_LONE_LOW;
                uq[1] = CONT;
                uq[2] = CONT | {4'h0, u[9:6]};
                uq[3] = CONT | {2'b00, u[5:0]};
                ucnt  = 3'd4;
            end
            else
            begin
                uq[0] = LEAD_THREE | {4'h0, u[15:12]};
                uq[1] = CONT | {2'b00, u[11:6]};
                uq[2] = CONT | {2'b00, u[5:0]};
                ucnt  = 3'd3;
            end
        end
    end

    // Pack the two parts in order and derive the next held state.
    always_comb
    begin
        result.final_unit = item.final_unit;
        result.held_valid = is_high && !item.final_unit;
        result.held_bits  = u[SURR_W-1:0];
        if (has_pre)
        begin
            result.bytes = {uq, pre};
            result.count = {1'b0, ucnt} + COUNT_W'(4);
        end
        else
        begin
            result.bytes = {32'h0, uq};
            result.count = {1'b0, ucnt};
        end
    end

endmodule

[rtl/core/u2u8_serialize.sv]
// Output buffer that holds one code unit's bytes and sends them one per cycle
// while byte_ch is ready, marking the last byte of the unit and of the text.
// Depends on u2u8_pkg and u2u8_byte_if.
module u2u8_serialize
    import u2u8_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  enc_result_t        result,
    output logic               load_ok,
    u2u8_byte_if.source        byte_ch
);

    octet_t             bytes_reg;
    octet_t             bytes_next;
    logic [COUNT_W-1:0] rem_reg;
    logic [COUNT_W-1:0] rem_next;
    logic               final_reg;
    logic               final_next;
    logic               pop;
    logic               last_byte;

    assign last_byte = (rem_reg == COUNT_W'(1));
    assign pop       = byte_ch.valid && byte_ch.ready;

    // The buffer can take new bytes when empty or when its last byte leaves now.
    assign load_ok = (rem_reg == '0) || (last_byte && byte_ch.ready);

    assign byte_ch.valid         = (rem_reg != '0);
    assign byte_ch.data.out_byte = bytes_reg[0];
    assign byte_ch.data.run_end  = last_byte;
    assign byte_ch.data.text_end = last_byte && final_reg;

    // Load a new group of bytes or shift the sent byte out.
    always_comb
    begin
        bytes_next = bytes_reg;
        rem_next   = rem_reg;
        final_next = final_reg;
        if (load)
        begin
            bytes_next = result.bytes;
            rem_next   = result.count;
            final_next = result.final_unit;
        end
        else if (pop)
        begin
            bytes_next = bytes_reg >> 8;
            rem_next   = rem_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg   <= '0;
            final_reg <= 1'b0;
        end
        else
        begin
            rem_reg   <= rem_next;
            final_reg <= final_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
    end

endmodule

[rtl/core/utf16_to_utf8_encoder.sv]
// Top level of the UTF-16 to UTF-8 encoder: input register, held surrogate
// state, encoder and output serializer.
// Depends on u2u8_pkg, u2u8_unit_if, u2u8_byte_if, u2u8_encode, u2u8_serialize.
//
//   Channel   Direction  Payload                            Transaction
//   unit_ch   in         code_unit[15:0], final_unit        one UTF-16 code unit
//   byte_ch   out        out_byte[7:0], run_end, text_end   one encoded byte
//
// A code unit is registered in the input register, encoded there and loaded
// into the output buffer, which sends one byte per cycle while byte_ch is
// ready. A unit causes up to 8 bytes (1 to 3 when no surrogate is held or
// met); a high surrogate that is only held causes no byte.
// The output buffer's single byte port sets the sustained rate.
// A new unit is taken while the previous unit's bytes are still being sent.
// Reset clears the held surrogate and empties both registers.
// A stall on byte_ch holds the current byte and backs up into unit_ch.
module utf16_to_utf8_encoder
    import u2u8_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    u2u8_unit_if.sink   unit_ch,
    u2u8_byte_if.source byte_ch
);

    logic              in_valid_reg;
    logic              in_valid_next;
    unit_t             in_item_reg;
    logic              held_valid_reg;
    logic              held_valid_next;
    logic [SURR_W-1:0] held_bits_reg;
    logic [SURR_W-1:0] held_bits_next;
    logic              load_ok;
    logic              advance;
    logic              take;
    enc_result_t       result;

    // The registered unit moves on as soon as the output buffer can take it.
    assign advance       = in_valid_reg && load_ok;
    assign unit_ch.ready = !in_valid_reg || advance;
    assign take          = unit_ch.valid && unit_ch.ready;

    u2u8_encode u_encode (
        .item       (in_item_reg),
        .held_valid (held_valid_reg),
        .held_bits  (held_bits_reg),
        .result     (result)
    );

    u2u8_serialize u_serialize (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (advance),
        .result  (result),
        .load_ok (load_ok),
        .byte_ch (byte_ch)
    );

    // Next values of the input register flag and the held surrogate.
    always_comb
    begin
        in_valid_next   = in_valid_reg;
        held_valid_next = held_valid_reg;
        held_bits_next  = held_bits_reg;
        if (take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        if (advance)
        begin
            held_valid_next = result.held_valid;
            held_bits_next  = result.held_bits;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            held_valid_reg <= 1'b0;
            held_bits_reg  <= '0;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            held_valid_reg <= held_valid_next;
            held_bits_reg  <= held_bits_next;
        end
    end

    // Input payload register.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_item_reg <= unit_ch.data;
        end
    end

endmodule

[rtl/core/u2u8_checker.sv]
// Port-level checks of the encoder's byte channel, bound to the top level.
// Depends on u2u8_pkg, utf16_to_utf8_encoder and its byte channel interface.
module u2u8_checker
    import u2u8_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       run_end,
    input logic       text_end
);

    // A stalled transaction keeps its byte and marks.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte)
            && $stable(run_end) && $stable(text_end))
        else $error("byte channel changed while stalled");

    // The end of the text is always the end of a unit's bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && text_end |-> run_end)
        else $error("text_end without run_end");

    // Bytes of one unit follow each other without a gap.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !run_end |=> out_valid)
        else $error("gap inside the bytes of one unit");

    // A lone-high lead byte is never the last byte of its unit.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_byte == LEAD_LONE_HIGH) |-> !run_end)
        else $error("lone high lead byte ends a unit");

endmodule

bind utf16_to_utf8_encoder u2u8_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (byte_ch.valid),
    .out_ready (byte_ch.ready),
    .out_byte  (byte_ch.data.out_byte),
    .run_end   (byte_ch.data.run_end),
    .text_end  (byte_ch.data.text_end)
);
